### sv/mdp_pkg.sv
`default_nettype none

package mdp_pkg;

  localparam int unsigned MaxParamsDefault = 255;

  // descriptor characters
  localparam logic [7:0] ChOpen   = 8'h28;  // (
  localparam logic [7:0] ChClose  = 8'h29;  // )
  localparam logic [7:0] ChSemi   = 8'h3B;  // ;
  localparam logic [7:0] ChLBrack = 8'h5B;  // [
  localparam logic [7:0] ChObject = 8'h4C;  // L

  // result kinds
  localparam logic [1:0] KindParam  = 2'd0;
  localparam logic [1:0] KindReturn = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  // type codes
  localparam logic [3:0] CodeByte    = 4'd0;
  localparam logic [3:0] CodeChar    = 4'd1;
  localparam logic [3:0] CodeDouble  = 4'd2;
  localparam logic [3:0] CodeFloat   = 4'd3;
  localparam logic [3:0] CodeInt     = 4'd4;
  localparam logic [3:0] CodeLong    = 4'd5;
  localparam logic [3:0] CodeRef     = 4'd6;
  localparam logic [3:0] CodeShort   = 4'd7;
  localparam logic [3:0] CodeBoolean = 4'd8;
  localparam logic [3:0] CodeVoid    = 4'd9;
  localparam logic [3:0] CodeUnknown = 4'd10;

  typedef struct packed {
    logic       is_open;
    logic       is_close;
    logic       is_semi;
    logic       is_lbrack;
    logic       is_object;
    logic       is_prim;
    logic [3:0] prim_code;
    logic [3:0] ret_code;
  } char_class_t;

  function automatic logic [3:0] prim_code(input logic [7:0] c);
    logic [3:0] code;
    case (c)
      8'h42:   code = CodeByte;     // B
      8'h43:   code = CodeChar;     // C
      8'h44:   code = CodeDouble;   // D
      8'h46:   code = CodeFloat;    // F
      8'h49:   code = CodeInt;      // I
      8'h4A:   code = CodeLong;     // J
      8'h53:   code = CodeShort;    // S
      8'h5A:   code = CodeBoolean;  // Z
      8'h56:   code = CodeVoid;     // V
      default: code = CodeUnknown;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/mdp_classify.sv
`default_nettype none

module mdp_classify (
  input  logic [7:0]          character_i,
  output mdp_pkg::char_class_t class_o
);
  import mdp_pkg::*;

  logic [3:0] prim;

  assign prim = prim_code(character_i);

  always_comb begin
    class_o.is_open   = (character_i == ChOpen);
    class_o.is_close  = (character_i == ChClose);
    class_o.is_semi   = (character_i == ChSemi);
    class_o.is_lbrack = (character_i == ChLBrack);
    class_o.is_object = (character_i == ChObject);
    class_o.is_prim   = (prim != CodeUnknown);
    class_o.prim_code = prim;
    // return type: arrays and objects are references, anything unknown is void
    if (class_o.is_object || class_o.is_lbrack) begin
      class_o.ret_code = CodeRef;
    end else if (prim == CodeUnknown) begin
      class_o.ret_code = CodeVoid;
    end else begin
      class_o.ret_code = prim;
    end
  end

endmodule

`default_nettype wire

### sv/method_descriptor_parser_top.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | character_i, final_char_i
// out     | output    | out_valid_o / out_ready_i| kind_o, type_code_o, arg_index_o,
//         |           |                          | count_saturated_o
// one character per cycle while in_ready_o is high: the parse state updates in the cycle of the
// transfer and the result, if any, lands in the output register on the same edge
// a result appears on the out channel in the cycle after its character is taken
// in_ready_o drops only while a result sits in the output register and is stalled
// reset clears the parse state and the output valid; payload registers are not reset
`default_nettype none

module method_descriptor_parser_top #(
  parameter int unsigned MaxParams = mdp_pkg::MaxParamsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       final_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [3:0] type_code_o,
  output logic [7:0] arg_index_o,
  output logic       count_saturated_o
);
  import mdp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxParams + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxParams);

  // parse phases
  localparam logic [2:0] PhStart  = 3'd0;  // expecting '('
  localparam logic [2:0] PhParams = 3'd1;  // inside the parameter list
  localparam logic [2:0] PhArray  = 3'd2;  // after one or more '['
  localparam logic [2:0] PhClass  = 3'd3;  // skipping a class name up to ';'
  localparam logic [2:0] PhRet    = 3'd4;  // next character is the return type
  localparam logic [2:0] PhDone   = 3'd5;  // ignore until the final character

  logic [2:0]      phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic            out_valid_q;
  logic [1:0]      kind_q, kind_d;
  logic [3:0]      code_q, code_d;
  logic [7:0]      idx_q, idx_d;
  logic            sat_q;

  logic            in_xfer;
  logic            emit;
  logic            emit_param;
  logic [3:0]      param_code;
  logic [CntW-1:0] pos;
  char_class_t     cls;

  mdp_classify u_classify (
    .character_i (character_i),
    .class_o     (cls)
  );

  // output register frees up on the same edge its result is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // phase transitions and result selection
  always_comb begin
    phase_d    = phase_q;
    emit       = 1'b0;
    emit_param = 1'b0;
    param_code = CodeRef;
    kind_d     = KindError;
    code_d     = CodeUnknown;
    case (phase_q)
      PhStart: begin
        if (cls.is_open) begin
          if (final_char_i) begin
            emit = 1'b1;
          end else begin
            phase_d = PhParams;
          end
        end else begin
          // no parameter list: first character is the return type
          emit    = 1'b1;
          kind_d  = KindReturn;
          code_d  = cls.ret_code;
          phase_d = PhDone;
        end
      end
      PhParams: begin
        if (cls.is_close) begin
          if (final_char_i) begin
            emit   = 1'b1;
            kind_d = KindReturn;
            code_d = CodeVoid;
          end else begin
            phase_d = PhRet;
          end
        end else if (final_char_i) begin
          emit = 1'b1;
        end else if (cls.is_lbrack) begin
          phase_d = PhArray;
        end else if (cls.is_object) begin
          phase_d = PhClass;
        end else begin
          emit_param = 1'b1;
          param_code = cls.prim_code;
        end
      end
      PhArray: begin
        if (final_char_i) begin
          emit = 1'b1;
        end else if (cls.is_lbrack) begin
          phase_d = PhArray;
        end else if (cls.is_prim) begin
          emit_param = 1'b1;
          phase_d    = PhParams;
        end else begin
          // any other element type starts a class name
          phase_d = PhClass;
        end
      end
      PhClass: begin
        if (final_char_i) begin
          emit = 1'b1;
        end else if (cls.is_semi) begin
          emit_param = 1'b1;
          phase_d    = PhParams;
        end
      end
      PhRet: begin
        emit    = 1'b1;
        kind_d  = KindReturn;
        code_d  = cls.ret_code;
        phase_d = PhDone;
      end
      default: begin
        phase_d = PhDone;
      end
    endcase

    if (emit_param) begin
      kind_d = KindParam;
      code_d = param_code;
    end
  end

  // parameter counter, saturating at the bound
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    pos     = count_q;
    if (emit_param) begin
      if (count_q >= CntMax) begin
        count_d = CntMax;
        ovf_d   = 1'b1;
        pos     = CntMax;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
    idx_d = (32'(pos) > 32'd255) ? 8'hFF : 8'(pos);
  end

  // parse state; a final character returns everything to start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (in_xfer) begin
      if (final_char_i) begin
        phase_q <= PhStart;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_xfer && (emit || emit_param);
    end
  end

  // output payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (in_xfer && (emit || emit_param)) begin
      kind_q <= kind_d;
      code_q <= code_d;
      idx_q  <= idx_d;
      sat_q  <= ovf_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign type_code_o       = code_q;
  assign arg_index_o       = idx_q;
  assign count_saturated_o = sat_q;

  // counter never passes the bound
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("parameter count above bound");

  // overflow flag only with a saturated counter
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CntMax))
    else $error("overflow flag set below bound");

  // a final character restarts the parse
  a_final_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && final_char_i) |=> (phase_q == PhStart && count_q == '0 && !ovf_q))
    else $error("parse state not cleared after final character");

  // error results always carry the unknown code
  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindError) |-> (type_code_o == CodeUnknown))
    else $error("error result with a type code");

endmodule

`default_nettype wire
